// File: hdl/gha_pkg.sv
`default_nettype none

package gha_pkg;

   // Handle geometry
   localparam int IDX_W       = 12;
   localparam int GEN_W       = 8;
   localparam int FILL_W      = IDX_W + 1;
   localparam int RUN_W       = 7;
   localparam int INDEX_SLOTS = 1 << IDX_W;
   localparam int MAX_RUN     = 64;
   localparam int TOTAL_W     = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   typedef logic [IDX_W-1:0]      index_type;
   typedef logic [GEN_W-1:0]      gen_type;
   typedef logic [FILL_W-1:0]     fill_type;
   typedef logic [RUN_W-1:0]      run_type;
   typedef logic [1:0]            mode_type;
   typedef logic [1:0]            status_type;
   typedef logic [TOTAL_W-1:0]    total_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   // Request modes
   localparam mode_type MODE_CREATE  = 2'd0;
   localparam mode_type MODE_RUN     = 2'd1;
   localparam mode_type MODE_DESTROY = 2'd2;

   // Result status codes
   localparam status_type STAT_CREATED   = 2'd0;
   localparam status_type STAT_FULL      = 2'd1;
   localparam status_type STAT_DESTROYED = 2'd2;
   localparam status_type STAT_STALE     = 2'd3;

   // Register indexes
   localparam logic REG_REUSE_MIN_FREE = 1'b0;

endpackage

`default_nettype wire

// File: hdl/gha_req_if.sv
`default_nettype none

interface gha_req_if;
   logic                valid;
   logic                ready;
   gha_pkg::mode_type   mode;
   gha_pkg::run_type    run_length;
   gha_pkg::index_type  handle_index;
   gha_pkg::gen_type    handle_generation;

   modport source (output valid, mode, run_length, handle_index, handle_generation,
                   input ready);
   modport sink   (input valid, mode, run_length, handle_index, handle_generation,
                   output ready);
endinterface

`default_nettype wire

// File: hdl/gha_rsp_if.sv
`default_nettype none

interface gha_rsp_if;
   logic                 valid;
   logic                 ready;
   gha_pkg::index_type   out_index;
   gha_pkg::gen_type     out_generation;
   gha_pkg::status_type  status;
   logic                 last;
   gha_pkg::index_type   active_count;
   gha_pkg::total_type   total_count;

   modport source (output valid, out_index, out_generation, status, last, active_count,
                   total_count, input ready);
   modport sink   (input valid, out_index, out_generation, status, last, active_count,
                   total_count, output ready);
endinterface

`default_nettype wire

// File: hdl/gha_csr.sv
`default_nettype none

module gha_csr (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  gha_pkg::csr_addr_type  csr_paddr,
   input  gha_pkg::csr_data_type  csr_pwdata,
   output gha_pkg::csr_data_type  csr_prdata,
   output logic                   csr_pready,
   output gha_pkg::index_type     reuse_min_free
);
   import gha_pkg::*;

   index_type reuse_min_free_ff;
   index_type reuse_min_free_in;
   logic      wr_hit;

   // register index sits above the word offset
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[CSR_ADDR_W-1] == REG_REUSE_MIN_FREE);

   always_comb begin
      reuse_min_free_in = reuse_min_free_ff;
      if (wr_hit) begin
         reuse_min_free_in = csr_pwdata[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reuse_min_free_ff <= '0;
      end else begin
         reuse_min_free_ff <= reuse_min_free_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1] == REG_REUSE_MIN_FREE) begin
         csr_prdata = CSR_DATA_W'(reuse_min_free_ff);
      end
   end

   assign csr_pready     = 1'b1;
   assign reuse_min_free = reuse_min_free_ff;

endmodule

`default_nettype wire

// File: hdl/generational_handle_allocator.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// req_chan  in   valid/ready        mode, run_length, handle_index, handle_generation
// rsp_chan  out  valid/ready        out_index, out_generation, status, last,
//                                   active_count, total_count
// csr_*     in   APB write/read     reuse_min_free at byte 0
//
// Steps: fresh create or table full goes through S_SINGLE; reuse create reads the free
// queue, then the generation table (S_QDATA, S_GDATA); destroy reads the generation
// (S_GDATA); a contiguous run emits its handles from S_RUN. Each memory has one read
// port and the generation table one write port; one item is in work at a time.
// Reset clears counters and queue pointers and sets the fresh index to 1; the memories
// are not cleared, and a destroy may read an unwritten entry. No clearing pass.
// A stalled rsp_chan holds the item in its current state; the output register lets
// the next request be taken while a result waits.

module generational_handle_allocator (
   input  wire                    clock,
   input  wire                    reset,
   gha_req_if.sink                req_chan,
   gha_rsp_if.source              rsp_chan,
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  gha_pkg::csr_addr_type  csr_paddr,
   input  gha_pkg::csr_data_type  csr_pwdata,
   output gha_pkg::csr_data_type  csr_prdata,
   output logic                   csr_pready
);
   import gha_pkg::*;

   // sequencer codes
   localparam logic [2:0] S_IDLE   = 3'd0;  // take a request
   localparam logic [2:0] S_QDATA  = 3'd1;  // free queue read data valid
   localparam logic [2:0] S_GDATA  = 3'd2;  // generation read data valid
   localparam logic [2:0] S_SINGLE = 3'd3;  // fresh create or table full
   localparam logic [2:0] S_RUN    = 3'd4;  // one handle of a contiguous run per cycle while rsp_chan is free

   localparam fill_type SLOTS_F = FILL_W'(INDEX_SLOTS);
   localparam gen_type  GEN_ONE = GEN_W'(1);

   index_type reuse_min_free;

   gha_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .reuse_min_free (reuse_min_free)
   );

   // -------------------------------------------------------------------------
   // State
   // -------------------------------------------------------------------------
   logic [2:0] state_ff, state_in;
   mode_type   op_ff, op_in;
   index_type  hidx_ff, hidx_in;
   gen_type    hgen_ff, hgen_in;
   run_type    run_left_ff, run_left_in;

   fill_type   fresh_ff, fresh_in;   // next fresh index, 1..INDEX_SLOTS
   index_type  head_ff, head_in;
   index_type  tail_ff, tail_in;
   fill_type   fill_ff, fill_in;
   index_type  live_ff, live_in;
   total_type  total_ff, total_in;

   // memories
   gen_type    gen_mem [INDEX_SLOTS];
   index_type  queue_mem [INDEX_SLOTS];
   gen_type    gen_rdata_ff;
   index_type  q_rdata_ff;

   logic       gen_rd_en;
   index_type  gen_rd_addr;
   logic       gen_wr_en;
   index_type  gen_wr_addr;
   gen_type    gen_wr_data;
   logic       q_rd_en;
   logic       q_wr_en;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   index_type  rsp_index_ff;
   gen_type    rsp_gen_ff;
   status_type rsp_status_ff;
   logic       rsp_last_ff;
   index_type  rsp_active_ff;
   total_type  rsp_total_ff;

   logic       emit;
   index_type  e_index;
   gen_type    e_gen;
   status_type e_status;
   logic       e_last;

   logic       out_free;
   run_type    run_sat;
   logic       run_fits;
   logic       live_hit;
   gen_type    gen_bump;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign run_sat  = (req_chan.run_length > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN)
                                                             : req_chan.run_length;
   assign run_fits = ({1'b0, fresh_ff} + (FILL_W+1)'(run_sat)) <= (FILL_W+1)'(INDEX_SLOTS);

   // destroy target: handed out, nonzero, generation matches, queue has room
   assign live_hit = (hidx_ff != '0) && ({1'b0, hidx_ff} < fresh_ff) &&
                     (gen_rdata_ff == hgen_ff) && (fill_ff < SLOTS_F);
   // generation wraps and skips zero
   assign gen_bump = ((gen_rdata_ff + GEN_ONE) == '0) ? GEN_ONE : (gen_rdata_ff + GEN_ONE);

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      hidx_in     = hidx_ff;
      hgen_in     = hgen_ff;
      run_left_in = run_left_ff;
      fresh_in    = fresh_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      live_in     = live_ff;
      total_in    = total_ff;
      gen_rd_en   = 1'b0;
      gen_rd_addr = req_chan.handle_index;
      gen_wr_en   = 1'b0;
      gen_wr_addr = hidx_ff;
      gen_wr_data = GEN_ONE;
      q_rd_en     = 1'b0;
      q_wr_en     = 1'b0;
      emit        = 1'b0;
      e_index     = '0;
      e_gen       = '0;
      e_status    = STAT_FULL;
      e_last      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in       = req_chan.mode;
               hidx_in     = req_chan.handle_index;
               hgen_in     = req_chan.handle_generation;
               run_left_in = run_sat;
               case (req_chan.mode)
                  MODE_CREATE: begin
                     if (fill_ff > {1'b0, reuse_min_free}) begin
                        q_rd_en  = 1'b1;
                        state_in = S_QDATA;
                     end else begin
                        state_in = S_SINGLE;
                     end
                  end
                  MODE_RUN: begin
                     // zero length: nothing to report
                     if (req_chan.run_length != '0) begin
                        state_in = run_fits ? S_RUN : S_SINGLE;
                     end
                  end
                  MODE_DESTROY: begin
                     gen_rd_en = 1'b1;
                     state_in  = S_GDATA;
                  end
                  default: begin
                     // unused mode: dropped
                  end
               endcase
            end
         end

         S_QDATA: begin
            gen_rd_en   = 1'b1;
            gen_rd_addr = q_rdata_ff;
            state_in    = S_GDATA;
         end

         S_GDATA: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (op_ff == MODE_DESTROY) begin
                  e_index = hidx_ff;
                  if (live_hit) begin
                     gen_wr_en   = 1'b1;
                     gen_wr_data = gen_bump;
                     q_wr_en     = 1'b1;
                     tail_in     = tail_ff + 1'b1;
                     fill_in     = fill_ff + 1'b1;
                     live_in     = live_ff - 1'b1;
                     e_status    = STAT_DESTROYED;
                  end else begin
                     e_status    = STAT_STALE;
                  end
               end else begin
                  // reuse of the oldest freed index
                  head_in  = head_ff + 1'b1;
                  fill_in  = fill_ff - 1'b1;
                  live_in  = live_ff + 1'b1;
                  total_in = total_ff + 1'b1;
                  e_index  = q_rdata_ff;
                  e_gen    = gen_rdata_ff;
                  e_status = STAT_CREATED;
               end
            end
         end

         S_SINGLE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if ((op_ff == MODE_CREATE) && (fresh_ff < SLOTS_F)) begin
                  gen_wr_en   = 1'b1;
                  gen_wr_addr = fresh_ff[IDX_W-1:0];
                  fresh_in    = fresh_ff + 1'b1;
                  live_in     = live_ff + 1'b1;
                  total_in    = total_ff + 1'b1;
                  e_index     = fresh_ff[IDX_W-1:0];
                  e_gen       = GEN_ONE;
                  e_status    = STAT_CREATED;
               end
            end
         end

         S_RUN: begin
            if (out_free) begin
               emit        = 1'b1;
               gen_wr_en   = 1'b1;
               gen_wr_addr = fresh_ff[IDX_W-1:0];
               fresh_in    = fresh_ff + 1'b1;
               live_in     = live_ff + 1'b1;
               total_in    = total_ff + 1'b1;
               run_left_in = run_left_ff - 1'b1;
               e_index     = fresh_ff[IDX_W-1:0];
               e_gen       = GEN_ONE;
               e_status    = STAT_CREATED;
               e_last      = (run_left_ff == RUN_W'(1));
               if (e_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fresh_ff     <= FILL_W'(1);
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         live_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         live_ff      <= live_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload: no reset
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      hidx_ff     <= hidx_in;
      hgen_ff     <= hgen_in;
      run_left_ff <= run_left_in;
      if (emit) begin
         rsp_index_ff  <= e_index;
         rsp_gen_ff    <= e_gen;
         rsp_status_ff <= e_status;
         rsp_last_ff   <= e_last;
         rsp_active_ff <= live_in;
         rsp_total_ff  <= total_in;
      end
   end

   // generation table: one read, one write port
   always_ff @(posedge clock) begin
      if (gen_wr_en) begin
         gen_mem[gen_wr_addr] <= gen_wr_data;
      end
      if (gen_rd_en) begin
         gen_rdata_ff <= gen_mem[gen_rd_addr];
      end
   end

   // free queue: read at head, write at tail
   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         queue_mem[tail_ff] <= hidx_ff;
      end
      if (q_rd_en) begin
         q_rdata_ff <= queue_mem[head_ff];
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_index      = rsp_index_ff;
   assign rsp_chan.out_generation = rsp_gen_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.last           = rsp_last_ff;
   assign rsp_chan.active_count   = rsp_active_ff;
   assign rsp_chan.total_count    = rsp_total_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= SLOTS_F)
      else $error("free queue fill above capacity");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      (fresh_ff != '0) && (fresh_ff <= SLOTS_F))
      else $error("fresh limit out of range");

   a_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      gen_wr_en |-> (gen_wr_data != '0))
      else $error("generation zero written");

   a_created_index: assert property (@(posedge clock) disable iff (reset)
      (emit && (e_status == STAT_CREATED)) |=> (rsp_index_ff != '0))
      else $error("created handle with index zero");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (run_left_ff != '0))
      else $error("run state with no handles left");

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(hidx_ff))
      else $error("request latched while busy");

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb;
   import gha_pkg::*;

   // One result as it leaves the allocator
   typedef struct {
      index_type  slot;
      gen_type    gen;
      status_type status;
      logic       last;
      index_type  active;
      total_type  total;
   } handle_result_type;

   // A handle the allocator currently considers live
   typedef struct {
      index_type slot;
      gen_type   gen;
   } live_handle_type;

   // Shadow of the allocator: generation table, fresh region, free FIFO and counters.
   // Every accepted request is applied here and its results are queued in order.
   class allocation_book;
      gen_type           gen_table [INDEX_SLOTS];
      int                fresh_limit;
      index_type         free_list [$];
      index_type         live_count;
      total_type         created_count;
      index_type         reuse_floor;
      live_handle_type   live [$];
      handle_result_type due [$];
      int                errors;
      int                full_single;
      int                full_run;

      function new();
         fresh_limit   = 1;
         live_count    = '0;
         created_count = '0;
         reuse_floor   = '0;
         errors        = 0;
         full_single   = 0;
         full_run      = 0;
      endfunction

      function void post(index_type slot, gen_type gen, status_type st, logic last);
         handle_result_type r;
         r.slot   = slot;
         r.gen    = gen;
         r.status = st;
         r.last   = last;
         r.active = live_count;
         r.total  = created_count;
         due.insert(due.size(), r);
      endfunction

      function void grant(index_type slot, logic last);
         live_handle_type h;
         created_count++;
         live_count++;
         h.slot = slot;
         h.gen  = gen_table[slot];
         live.insert(live.size(), h);
         post(slot, gen_table[slot], STAT_CREATED, last);
      endfunction

      function void reject(bit from_run);
         if (from_run)
            full_run++;
         else
            full_single++;
         post('0, '0, STAT_FULL, 1'b1);
      endfunction

      function void apply_request(mode_type m, run_type r, index_type slot, gen_type gen);
         int        n;
         int        k;
         index_type pick;
         case (m)
            MODE_CREATE: begin
               if (free_list.size() > reuse_floor) begin
                  pick = free_list[0];
                  free_list.delete(0);
                  grant(pick, 1'b1);
               end else if (fresh_limit < INDEX_SLOTS) begin
                  pick = index_type'(fresh_limit);
                  gen_table[pick] = gen_type'(1);
                  fresh_limit++;
                  grant(pick, 1'b1);
               end else begin
                  reject(1'b0);
               end
            end
            MODE_RUN: begin
               n = (r > MAX_RUN) ? MAX_RUN : int'(r);
               if (n == 0)
                  return;
               if (fresh_limit + n > INDEX_SLOTS) begin
                  reject(1'b1);
               end else begin
                  for (k = 0; k < n; k++) begin
                     pick = index_type'(fresh_limit);
                     gen_table[pick] = gen_type'(1);
                     fresh_limit++;
                     grant(pick, k == n - 1);
                  end
               end
            end
            MODE_DESTROY: begin
               if (slot != 0 && slot < fresh_limit && gen_table[slot] == gen &&
                   free_list.size() < INDEX_SLOTS) begin
                  gen_table[slot] = gen_table[slot] + 1'b1;
                  if (gen_table[slot] == '0)
                     gen_table[slot] = gen_type'(1);
                  free_list.insert(free_list.size(), slot);
                  live_count--;
                  for (k = 0; k < live.size(); k++) begin
                     if (live[k].slot == slot) begin
                        live.delete(k);
                        break;
                     end
                  end
                  post(slot, '0, STAT_DESTROYED, 1'b1);
               end else begin
                  post(slot, '0, STAT_STALE, 1'b1);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void match_result(handle_result_type got);
         handle_result_type want;
         if (due.size() == 0) begin
            $error("unexpected result: out_index 0x%0h status %0d", got.slot, got.status);
            errors++;
            return;
         end
         want = due[0];
         due.delete(0);
         check_field("out_index", want.slot, got.slot);
         check_field("out_generation", want.gen, got.gen);
         check_field("status", want.status, got.status);
         check_field("last", want.last, got.last);
         check_field("active_count", want.active, got.active);
         check_field("total_count", want.total, got.total);
      endfunction
   endclass

   // mode 3 has no name in the package; the allocator ignores it
   localparam mode_type     MODE_UNUSED    = 2'd3;
   localparam csr_addr_type FLOOR_ADDR     = csr_addr_type'({REG_REUSE_MIN_FREE, 2'b00});
   // longest item is a 64-handle run; the settle time covers it with margin
   localparam int           SETTLE_CYCLES  = 70;
   // cycles with no transaction on any port before the run is declared hung
   localparam int           WATCHDOG_LIMIT = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         rsp_ready = 1'b0;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   csr_addr_type csr_paddr = '0;
   csr_data_type csr_pwdata = '0;
   csr_data_type csr_prdata;
   logic         csr_pready;

   allocation_book book;
   int             req_quiet = 0;
   int             rsp_quiet = 0;
   int             rsp_hold = 0;
   int             idle_cycles = 0;

   gha_req_if req_bus ();
   gha_rsp_if rsp_bus ();

   assign rsp_bus.ready = rsp_ready;

   generational_handle_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap length: mostly none or short, a few long; now and then a quiet stretch
   // of back-to-back transactions.
   function automatic int draw_gap(inout int quiet);
      int roll;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 3)
         quiet = $urandom_range(40, 10);
      if (roll < 50)
         return 0;
      if (roll < 93)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Result side backpressure. ready goes low for random stretches.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(2) == 0)
            rsp_hold = draw_gap(rsp_quiet);
      end
   end

   // Result monitor: every accepted result goes against the oldest expectation.
   always @(posedge clock) begin
      handle_result_type seen;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.slot   = rsp_bus.out_index;
         seen.gen    = rsp_bus.out_generation;
         seen.status = rsp_bus.status;
         seen.last   = rsp_bus.last;
         seen.active = rsp_bus.active_count;
         seen.total  = rsp_bus.total_count;
         book.match_result(seen);
      end
   end

   // Watchdog: any transaction on any port restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // One request transaction. Called at a rising edge; returns at the edge of
   // acceptance, so a following call with no gap keeps valid high.
   task automatic send_request(mode_type m, run_type r, index_type slot, gen_type gen);
      int gap;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.mode              <= m;
      req_bus.run_length        <= r;
      req_bus.handle_index      <= slot;
      req_bus.handle_generation <= gen;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      book.apply_request(m, r, slot, gen);
   endtask

   // Hold the request side until all results are in. The do-while waits on the clock
   // before it checks, so valid is never dropped and raised in the same step.
   task automatic wait_idle(bit settle);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (book.due.size() != 0);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(bit write, csr_data_type wdata, output csr_data_type rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= FLOOR_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Only done with the allocator idle; write, then read back.
   task automatic set_reuse_floor(index_type value);
      csr_data_type rd;
      wait_idle(1'b1);
      csr_access(1'b1, csr_data_type'(value), rd);
      book.reuse_floor = value;
      csr_access(1'b0, '0, rd);
      if (rd[IDX_W-1:0] !== value) begin
         $error("reuse_min_free: expected 0x%0h, got 0x%0h", value, rd[IDX_W-1:0]);
         book.errors++;
      end
   endtask

   // Random request with the given mix (percent). Destroys mostly target live
   // handles, some with a corrupted generation; the rest hit random handles.
   // Remaining percent is ignored mode 3 traffic.
   task automatic send_mixed(int w_run, int w_create, int w_destroy, int run_min,
                             output bit counted);
      int        roll;
      int        k;
      mode_type  m;
      run_type   r;
      index_type slot;
      gen_type   gen;
      m    = MODE_UNUSED;
      r    = run_type'($urandom);
      slot = index_type'($urandom);
      gen  = gen_type'($urandom);
      roll = $urandom_range(99);
      if (roll < w_run) begin
         m = MODE_RUN;
         r = ($urandom_range(9) == 0) ? run_type'($urandom_range(127))
                                      : run_type'($urandom_range(MAX_RUN, run_min));
      end else if (roll < w_run + w_create) begin
         m = MODE_CREATE;
      end else if (roll < w_run + w_create + w_destroy) begin
         m = MODE_DESTROY;
         if (book.live.size() != 0 && $urandom_range(4) != 0) begin
            k    = $urandom_range(book.live.size() - 1);
            slot = book.live[k].slot;
            gen  = book.live[k].gen;
            if ($urandom_range(5) == 0)
               gen = gen ^ gen_type'($urandom_range(255, 1));
         end
      end
      counted = (m != MODE_UNUSED) && !(m == MODE_RUN && r == 0);
      send_request(m, r, slot, gen);
   endtask

   initial begin
      live_handle_type sweep;
      int              n;
      bit              counted;

      book = new();
      req_bus.valid             <= 1'b0;
      req_bus.mode              <= MODE_CREATE;
      req_bus.run_length        <= '0;
      req_bus.handle_index      <= '0;
      req_bus.handle_generation <= '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_reuse_floor('0);

      // --- directed: field extremes, every mode, each corner of the spec ---
      send_request(MODE_UNUSED, run_type'(127), index_type'(4095), gen_type'(255));
      send_request(MODE_DESTROY, run_type'($urandom), '0, '0);            // index zero
      send_request(MODE_DESTROY, '0, index_type'(4095), gen_type'(255));  // never handed out
      send_request(MODE_CREATE, run_type'(127), index_type'(4095), gen_type'(255));
      send_request(MODE_RUN, '0, index_type'($urandom), gen_type'($urandom)); // empty run
      send_request(MODE_RUN, run_type'(1), '0, '0);
      send_request(MODE_RUN, run_type'(MAX_RUN), index_type'($urandom), '0);
      send_request(MODE_RUN, run_type'(127), '0, gen_type'(255));         // saturates
      send_request(MODE_RUN, run_type'(MAX_RUN + 1), '0, '0);             // saturates
      send_request(MODE_DESTROY, '0, index_type'(1), '0);                 // wrong generation
      send_request(MODE_DESTROY, run_type'(127), index_type'(1), gen_type'(1));
      send_request(MODE_DESTROY, '0, index_type'(1), gen_type'(1));       // already freed
      send_request(MODE_CREATE, '0, '0, '0);                              // reuses slot 1
      send_request(MODE_DESTROY, '0, index_type'(book.fresh_limit), gen_type'(1));
      send_request(MODE_DESTROY, '0, index_type'(2), gen_type'(255));
      send_request(MODE_UNUSED, '0, '0, '0);

      // --- generation sweep: one handle destroyed and recreated a number of
      // times, each pass bumping its generation ---
      while (book.free_list.size() != 0)
         send_request(MODE_CREATE, run_type'($urandom), index_type'($urandom),
                      gen_type'($urandom));
      sweep = book.live[0];
      repeat (24) begin
         send_request(MODE_DESTROY, run_type'($urandom), sweep.slot, sweep.gen);
         send_request(MODE_CREATE, run_type'($urandom), index_type'($urandom),
                      gen_type'($urandom));
         sweep.gen = book.gen_table[sweep.slot];
      end

      // --- fill: reuse disabled, long runs until the fresh region is gone and
      // both kinds of table-full result have shown up several times ---
      set_reuse_floor(index_type'(4095));
      n = 0;
      while ((book.fresh_limit < INDEX_SLOTS || book.full_single < 3 ||
              book.full_run < 3) && n < 300) begin
         send_mixed(70, 15, 10, 40, counted);
         n += counted;
      end

      // --- churn on a full table: reuse with a small floor, then with no floor ---
      set_reuse_floor(index_type'($urandom_range(6, 1)));
      n = 0;
      while (n < 50) begin
         send_mixed(10, 40, 45, 1, counted);
         n += counted;
         if (n == 25 || $urandom_range(33) == 0)
            wait_idle(1'b0);   // sender holds off until every result is back
      end
      set_reuse_floor('0);
      n = 0;
      while (n < 50) begin
         send_mixed(10, 40, 45, 1, counted);
         n += counted;
         if ($urandom_range(33) == 0)
            wait_idle(1'b0);
      end

      wait_idle(1'b1);
      if (book.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

`default_nettype wire
